### hw/rtl/tmdv_pkg.sv
// Shared types and constants for the term metadata delta varint encoder.
package tmdv_pkg;

   // Fixed field widths of the term record and the output byte
   localparam int IN_PTR_BITS   = 48;
   localparam int DOC_ID_BITS   = 31;
   localparam int OFFSET_BITS   = 48;
   localparam int VAL_BITS      = 64;
   localparam int BYTE_BITS     = 8;
   localparam int GROUP_BITS    = 7;

   // Defaults for the top-level parameters
   localparam int TMDV_PTR_BITS    = 48;
   localparam int TMDV_QUEUE_DEPTH = 4;

   // Varint fields of one term, in emission order
   typedef enum logic [1:0] {
      FLD_DOC,
      FLD_SDOC,
      FLD_POS,
      FLD_OFF
   } fld_type;

   // One classified term waiting for serialisation
   typedef struct packed {
      logic [VAL_BITS-1:0]    doc_val;
      logic                   has_sdoc;
      logic [DOC_ID_BITS-1:0] sdoc;
      logic                   has_pos;
      logic [VAL_BITS-1:0]    pos_val;
      logic                   has_off;
      logic [OFFSET_BITS-1:0] off;
   } job_type;

   // Queue status seen by the front and back parts
   typedef struct packed {
      logic full;
      logic not_empty;
   } qstat_type;

endpackage

### hw/rtl/tmdv_front.sv
// Front part: accepts term beats, keeps previous-term state and builds jobs.
module tmdv_front #(
   parameter int PTR_BITS = tmdv_pkg::TMDV_PTR_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_absolute,
   input  logic [tmdv_pkg::IN_PTR_BITS-1:0]      req_doc_start_ptr,
   input  logic [tmdv_pkg::IN_PTR_BITS-1:0]      req_pos_start_ptr,
   input  logic                                  req_is_singleton,
   input  logic [tmdv_pkg::DOC_ID_BITS-1:0]      req_singleton_doc,
   input  logic                                  req_has_pos_offset,
   input  logic [tmdv_pkg::OFFSET_BITS-1:0]      req_pos_block_offset,
   input  logic                                  positions_enabled,
   input  tmdv_pkg::qstat_type                   qstat,
   output logic                                  push,
   output tmdv_pkg::job_type                     job
);
   import tmdv_pkg::*;

   // Stored pointer width: the pointer ports cap the mask
   localparam int PW = (PTR_BITS < IN_PTR_BITS) ? PTR_BITS : IN_PTR_BITS;

   logic [PW-1:0]          prev_doc_ff, prev_doc_in;
   logic [PW-1:0]          prev_pos_ff, prev_pos_in;
   logic                   prev_sv_ff, prev_sv_in;
   logic [DOC_ID_BITS-1:0] prev_id_ff, prev_id_in;

   logic [PW-1:0]          doc_m, pos_m, base_doc, base_pos;
   logic                   base_sv;
   logic [DOC_ID_BITS-1:0] base_id;
   logic [VAL_BITS-1:0]    doc_delta, pos_delta, id_delta, zz;
   logic                   same_single;

   // Take a beat whenever the queue has room
   assign req_stall = qstat.full;
   assign push      = req_valid && !qstat.full;

   // Mask pointers and apply the absolute flag to the previous state
   always_comb begin
      doc_m    = req_doc_start_ptr[PW-1:0];
      pos_m    = req_pos_start_ptr[PW-1:0];
      base_doc = req_absolute ? '0 : prev_doc_ff;
      base_pos = req_absolute ? '0 : prev_pos_ff;
      base_sv  = req_absolute ? 1'b0 : prev_sv_ff;
      base_id  = req_absolute ? '0 : prev_id_ff;
   end

   // Classify the term and form the 64-bit wrapped deltas
   always_comb begin
      doc_delta   = VAL_BITS'(doc_m) - VAL_BITS'(base_doc);
      pos_delta   = VAL_BITS'(pos_m) - VAL_BITS'(base_pos);
      id_delta    = VAL_BITS'(req_singleton_doc) - VAL_BITS'(base_id);
      zz          = {id_delta[VAL_BITS-2:0], 1'b0} ^ {VAL_BITS{id_delta[VAL_BITS-1]}};
      same_single = base_sv && req_is_singleton && (doc_m == base_doc);

      job.doc_val  = same_single ? {zz[VAL_BITS-2:0], 1'b1}
                                 : {doc_delta[VAL_BITS-2:0], 1'b0};
      job.has_sdoc = req_is_singleton && !same_single;
      job.sdoc     = req_singleton_doc;
      job.has_pos  = positions_enabled;
      job.pos_val  = pos_delta;
      job.has_off  = positions_enabled && req_has_pos_offset;
      job.off      = req_pos_block_offset;
   end

   // Advance previous-term state on each accepted beat
   always_comb begin
      prev_doc_in = prev_doc_ff;
      prev_pos_in = prev_pos_ff;
      prev_sv_in  = prev_sv_ff;
      prev_id_in  = prev_id_ff;
      if (push) begin
         prev_doc_in = doc_m;
         prev_pos_in = pos_m;
         prev_sv_in  = req_is_singleton;
         prev_id_in  = req_is_singleton ? req_singleton_doc : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_doc_ff <= '0;
         prev_pos_ff <= '0;
         prev_sv_ff  <= 1'b0;
         prev_id_ff  <= '0;
      end else begin
         prev_doc_ff <= prev_doc_in;
         prev_pos_ff <= prev_pos_in;
         prev_sv_ff  <= prev_sv_in;
         prev_id_ff  <= prev_id_in;
      end
   end

endmodule

### hw/rtl/tmdv_queue.sv
// Short job queue between the front and back parts.
module tmdv_queue #(
   parameter int QUEUE_DEPTH = tmdv_pkg::TMDV_QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tmdv_pkg::job_type   push_job,
   input  logic                pop,
   output tmdv_pkg::job_type   head_job,
   output tmdv_pkg::qstat_type qstat
);
   import tmdv_pkg::*;

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   job_type         q_ff [QUEUE_DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign qstat.full      = (count_ff == CW'(QUEUE_DEPTH));
   assign qstat.not_empty = (count_ff != '0);
   assign head_job        = q_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the job at the write pointer
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### hw/rtl/tmdv_back.sv
// Back part: serialises queued jobs into varint bytes through an output register.
module tmdv_back (
   input  logic                           clock,
   input  logic                           reset,
   input  tmdv_pkg::job_type              head_job,
   input  tmdv_pkg::qstat_type            qstat,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tmdv_pkg::BYTE_BITS-1:0] rsp_out_byte,
   output logic                           rsp_last_byte
);
   import tmdv_pkg::*;

   fld_type               fld_ff, fld_in;
   logic [VAL_BITS-1:0]   wrk_ff, wrk_in;
   logic                  live_ff, live_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BYTE_BITS-1:0]  byte_ff, byte_in;
   logic                  last_ff, last_in;

   logic [VAL_BITS-1:0]   head_val, cur;
   logic                  more, nxt_has, step;
   fld_type               nxt_fld;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_last_byte = last_ff;

   // Select the value of the current field from the queue head
   always_comb begin
      case (fld_ff)
         FLD_DOC:  head_val = head_job.doc_val;
         FLD_SDOC: head_val = VAL_BITS'(head_job.sdoc);
         FLD_POS:  head_val = head_job.pos_val;
         FLD_OFF:  head_val = VAL_BITS'(head_job.off);
         default:  head_val = '0;
      endcase
   end

   // Find the next present field after the current one
   always_comb begin
      nxt_has = 1'b0;
      nxt_fld = FLD_DOC;
      case (fld_ff)
         FLD_DOC: begin
            if (head_job.has_sdoc) begin
               nxt_has = 1'b1;
               nxt_fld = FLD_SDOC;
            end else if (head_job.has_pos) begin
               nxt_has = 1'b1;
               nxt_fld = FLD_POS;
            end
         end
         FLD_SDOC: begin
            if (head_job.has_pos) begin
               nxt_has = 1'b1;
               nxt_fld = FLD_POS;
            end
         end
         FLD_POS: begin
            if (head_job.has_off) begin
               nxt_has = 1'b1;
               nxt_fld = FLD_OFF;
            end
         end
         default: begin
            nxt_has = 1'b0;
            nxt_fld = FLD_DOC;
         end
      endcase
   end

   // Emit one byte per cycle while a job is queued and the output register can take it
   always_comb begin
      cur          = live_ff ? wrk_ff : head_val;
      more         = |cur[VAL_BITS-1:GROUP_BITS];
      step         = qstat.not_empty && (!rsp_valid_ff || !rsp_stall);
      pop          = step && !more && !nxt_has;
      fld_in       = fld_ff;
      wrk_in       = wrk_ff;
      live_in      = live_ff;
      rsp_valid_in = rsp_valid_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
         byte_in      = {more, cur[GROUP_BITS-1:0]};
         last_in      = !more && !nxt_has;
         if (more) begin
            wrk_in  = cur >> GROUP_BITS;
            live_in = 1'b1;
         end else begin
            live_in = 1'b0;
            fld_in  = nxt_has ? nxt_fld : FLD_DOC;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fld_ff       <= FLD_DOC;
         live_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fld_ff       <= fld_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload; no reset needed
   always_ff @(posedge clock) begin
      wrk_ff  <= wrk_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

endmodule

### hw/rtl/term_metadata_delta_varint_encoder_top.sv
// Top level of the term metadata delta varint encoder.
//
// Input channel (req_): one beat carries one term's postings metadata. The
// block keeps the previous term's pointers and singleton id, and turns each
// term into unsigned varint bytes (7 bits a byte, bit 7 = more follow).
// Result channel (rsp_): one byte a beat; rsp_last_byte marks a term's end.
// Config channel (csr_): csr_positions_enabled, written on csr_valid; the user
// must write it only while the block is idle, which the block itself does not enforce; csr_ready is always high.
// Throughput: one result byte per cycle while a job is queued and rsp_stall
// does not hold the output; a term has 1 to 32 bytes.
// The byte serialiser is the limit; the front takes a term each cycle while
// the job queue (QUEUE_DEPTH entries) has room, and raises req_stall when full.
// Path of a term: it is written into the job queue, and the back part then
// registers its first byte in the output register that drives rsp_out_byte.
// rsp_stall, while rsp_valid is high, holds the output register and stops serialisation; nothing is lost.
// Reset (synchronous) clears the previous-term state to zero, empties the
// queue, drops rsp_valid and sets positions_enabled.
module term_metadata_delta_varint_encoder_top #(
   parameter int PTR_BITS    = tmdv_pkg::TMDV_PTR_BITS,
   parameter int QUEUE_DEPTH = tmdv_pkg::TMDV_QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_positions_enabled,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_absolute,
   input  logic [tmdv_pkg::IN_PTR_BITS-1:0] req_doc_start_ptr,
   input  logic [tmdv_pkg::IN_PTR_BITS-1:0] req_pos_start_ptr,
   input  logic                             req_is_singleton,
   input  logic [tmdv_pkg::DOC_ID_BITS-1:0] req_singleton_doc,
   input  logic                             req_has_pos_offset,
   input  logic [tmdv_pkg::OFFSET_BITS-1:0] req_pos_block_offset,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [tmdv_pkg::BYTE_BITS-1:0]   rsp_out_byte,
   output logic                             rsp_last_byte
);
   import tmdv_pkg::*;

   logic      pos_en_ff, pos_en_in;
   logic      push, pop;
   job_type   push_job, head_job;
   qstat_type qstat;

   // Configuration register
   assign csr_ready = 1'b1;

   always_comb begin
      pos_en_in = pos_en_ff;
      if (csr_valid && csr_ready) begin
         pos_en_in = csr_positions_enabled;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_en_ff <= 1'b1;
      end else begin
         pos_en_ff <= pos_en_in;
      end
   end

   tmdv_front #(
      .PTR_BITS (PTR_BITS)
   ) u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_absolute         (req_absolute),
      .req_doc_start_ptr    (req_doc_start_ptr),
      .req_pos_start_ptr    (req_pos_start_ptr),
      .req_is_singleton     (req_is_singleton),
      .req_singleton_doc    (req_singleton_doc),
      .req_has_pos_offset   (req_has_pos_offset),
      .req_pos_block_offset (req_pos_block_offset),
      .positions_enabled    (pos_en_ff),
      .qstat                (qstat),
      .push                 (push),
      .job                  (push_job)
   );

   tmdv_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .qstat    (qstat)
   );

   tmdv_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_job      (head_job),
      .qstat         (qstat),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule

### hw/rtl/tmdv_checker.sv
// Port-level checker for the encoder top level, with its bind.
module tmdv_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [tmdv_pkg::BYTE_BITS-1:0] rsp_out_byte,
   input logic                           rsp_last_byte
);
   import tmdv_pkg::*;

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last_byte))
      else $error("stalled result beat changed");

   // The final byte of a term must close its varint
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_byte |-> !rsp_out_byte[BYTE_BITS-1])
      else $error("last byte carries a continuation bit");

   // Drop output after reset
   a_rst_rsp: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // Queue empty after reset, so input is open
   a_rst_req: assert property (@(posedge clock)
      $past(reset) |-> !req_stall)
      else $error("input stalled right after reset");

endmodule

bind term_metadata_delta_varint_encoder_top tmdv_checker u_tmdv_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_last_byte (rsp_last_byte)
);
